@@ sv/acsc_pkg.sv @@
package acsc_pkg;

	// Field widths
	localparam int CHAN_W   = 8;
	localparam int LVL_IN_W = 16;
	localparam int LEVEL_W  = 13;
	localparam int CODE_W   = 8;
	localparam int TICK_W   = 7;

	// Full scale in millivolts; a level is clamped to it
	localparam logic [LEVEL_W-1:0] FULL_SCALE_MV = 13'd5000;

	// code = floor(mv * 255 / 5000), computed as (mv * CODE_MULT) >> CODE_SHIFT.
	// CODE_MULT = ceil(255 * 2^26 / 5000); exact for every mv up to 2^13.
	localparam int MULT_W     = 22;
	localparam int CODE_SHIFT = 26;
	localparam int PROD_W     = LEVEL_W + MULT_W;
	localparam logic [MULT_W-1:0] CODE_MULT = 22'd3422553;

	// Operation codes carried on tuser
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_READ = 2'd1,
		OP_SET  = 2'd2,
		OP_GET  = 2'd3
	} op_t;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CODE_W-1:0]  code_t;

	// Scale a level (at most full scale) to an 8-bit code
	function automatic code_t level_to_code(input level_t mv);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(mv) * PROD_W'(CODE_MULT);
		return prod[CODE_SHIFT +: CODE_W];
	endfunction

	// Level of a channel after reset
	function automatic level_t reset_level(input int idx);
		level_t lvl;
		case (idx)
			0: lvl = 13'd2500;
			1: lvl = 13'd1000;
			2: lvl = 13'd4000;
			default: lvl = '0;
		endcase
		return lvl;
	endfunction

endpackage

@@ sv/adc_channel_scan_converter_core.sv @@
// Each accepted word goes through the input register, then the result register.
// Throughput: one word per cycle; input register, one scaling multiplier and the
// result register form the only path, so a new word enters every cycle unless the
// result register is full and stalled.
// Reset (arst_n low, asynchronous): levels 2500/1000/4000/0 mV on channels 0..3 and
// 0 elsewhere, all codes 0, idle, continuous mode off; no clearing pass.
module adc_channel_scan_converter_core #(
	parameter int NUM_CHANNELS     = 8,
	parameter int CONVERSION_TICKS = 100
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// slave side
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [23:0]               s_tdata,  // [7:0] channel, [23:8] level_in_mv
	input  logic [1:0]                s_tuser,  // [1:0] op
	// master side
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata,  // [7:0] code, [20:8] level_out_mv,
	                                            // [21] busy_res, [23:22] zero
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data  // continuous_mode
);
	import acsc_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [TICK_W-1:0] TICKS_INIT = TICK_W'(CONVERSION_TICKS);
	localparam logic [CH_W-1:0]   LAST_CH    = CH_W'(NUM_CHANNELS - 1);

	// input register
	logic                valid_s1;
	op_t                 op_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic [LVL_IN_W-1:0] lvl_s1;
	logic                adv_s1;

	// result register
	logic                out_valid_q;
	code_t               code_q;
	level_t              level_out_q;
	logic                busy_q;

	// converter state
	level_t              levels_q [NUM_CHANNELS];
	code_t               codes_q  [NUM_CHANNELS];
	logic [CH_W-1:0]     active_q;
	logic                conv_q;
	logic [TICK_W-1:0]   ticks_q;
	logic                cont_q;

	// next-state and result logic
	logic                ch_ok;
	logic [CH_W-1:0]     ch_idx;
	logic [CH_W-1:0]     lvl_addr;
	level_t              lvl_rd;
	level_t              lvl_clamp;
	level_t              conv_in;
	code_t               conv_code;
	logic [TICK_W-1:0]   ticks_dec;
	logic [CH_W-1:0]     next_ch;
	logic                conv_nxt;
	logic [TICK_W-1:0]   ticks_nxt;
	logic [CH_W-1:0]     active_nxt;
	code_t               code_res;
	level_t              level_res;
	logic                lvl_we;
	logic                code_we;
	logic [CH_W-1:0]     code_waddr;

	// handshakes
	assign adv_s1    = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, busy_q, level_out_q, code_q};

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser);
			chan_s1 <= s_tdata[CHAN_W-1:0];
			lvl_s1  <= s_tdata[CHAN_W +: LVL_IN_W];
		end
	end

	// channel decode, single level read port, shared scaler
	assign ch_ok     = chan_s1 < CHAN_W'(NUM_CHANNELS);
	assign ch_idx    = chan_s1[CH_W-1:0];
	assign lvl_addr  = (op_s1 == OP_TICK) ? active_q : ch_idx;
	assign lvl_rd    = levels_q[lvl_addr];
	assign lvl_clamp = (lvl_s1 > LVL_IN_W'(FULL_SCALE_MV)) ? FULL_SCALE_MV
	                                                        : lvl_s1[LEVEL_W-1:0];
	assign conv_in   = (op_s1 == OP_SET) ? lvl_clamp : lvl_rd;
	assign conv_code = level_to_code(conv_in);
	assign ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : '0;
	assign next_ch   = (active_q == LAST_CH) ? '0 : active_q + 1'b1;

	// per-op behavior
	always_comb begin
		conv_nxt   = conv_q;
		ticks_nxt  = ticks_q;
		active_nxt = active_q;
		code_res   = '0;
		level_res  = '0;
		lvl_we     = 1'b0;
		code_we    = 1'b0;
		code_waddr = ch_idx;
		case (op_s1)
			OP_TICK: begin
				if (conv_q) begin
					ticks_nxt = ticks_dec;
					if (ticks_dec == '0) begin
						// conversion done: store code, maybe rescan next channel
						code_we    = 1'b1;
						code_waddr = active_q;
						conv_nxt   = 1'b0;
						if (cont_q) begin
							active_nxt = next_ch;
							conv_nxt   = 1'b1;
							ticks_nxt  = TICKS_INIT;
						end
					end
				end
			end
			OP_READ: begin
				if (ch_ok) begin
					code_res = codes_q[ch_idx];
					if (!conv_q) begin
						active_nxt = ch_idx;
						conv_nxt   = 1'b1;
						ticks_nxt  = TICKS_INIT;
					end
				end
			end
			OP_SET: begin
				if (ch_ok) begin
					lvl_we  = 1'b1;
					code_we = 1'b1;
				end
			end
			OP_GET: begin
				if (ch_ok) begin
					level_res = lvl_rd;
				end
			end
			default: begin
			end
		endcase
	end

	// converter state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				levels_q[i] <= reset_level(i);
				codes_q[i]  <= '0;
			end
			active_q <= '0;
			conv_q   <= 1'b0;
			ticks_q  <= '0;
			cont_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cont_q <= cfg_data;
			end
			if (adv_s1) begin
				active_q <= active_nxt;
				conv_q   <= conv_nxt;
				ticks_q  <= ticks_nxt;
				if (lvl_we) begin
					levels_q[ch_idx] <= lvl_clamp;
				end
				if (code_we) begin
					codes_q[code_waddr] <= conv_code;
				end
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			code_q      <= code_res;
			level_out_q <= level_res;
			busy_q      <= conv_nxt;
		end
	end

	// a running conversion always has ticks left
	a_conv_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		conv_q |-> ticks_q != '0)
		else $error("conversion running with zero ticks left");

	// active channel stays in range
	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= LAST_CH)
		else $error("active channel out of range");

	// reported busy matches the converter state after the word
	a_busy_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> busy_q == conv_q)
		else $error("busy flag disagrees with converter state");

	// a stored level never exceeds full scale
	a_level_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && lvl_we |=> levels_q[$past(ch_idx)] <= FULL_SCALE_MV)
		else $error("stored level above full scale");

	// an idle tick leaves the converter idle
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == OP_TICK && !conv_q |=> !conv_q)
		else $error("tick started a conversion from idle");

endmodule
